FILE: rtl/patch_column_post_renderer_unit_defines.svh
`ifndef PATCH_COLUMN_POST_RENDERER_UNIT_DEFINES_SVH
`define PATCH_COLUMN_POST_RENDERER_UNIT_DEFINES_SVH

// Check a property on the rising clock edge, off while reset is asserted
`define PCPR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a signal holds while a beat waits for its receiver
`define PCPR_ASSERT_STABLE(label, valid, ready, sig, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    ((valid) && !(ready) |=> $stable(sig))) else $error(msg);

`endif

FILE: rtl/pcpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcpr_pkg;

  // Field and register widths
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int BaseW    = 22;
  localparam int LineW    = 12;
  localparam int ScaleW   = 20;
  localparam int StepW    = 23;
  localparam int ByteW    = 8;
  localparam int ColW     = 11;
  localparam int ProdW    = ByteW + ScaleW;
  localparam int TotalW   = 12;
  localparam int AccW     = 28;
  localparam int IdxW     = 9;
  localparam int CountW   = 5;
  localparam int FracBits = 16;

  // Most pixel writes caused by one column byte
  localparam int ResCap = 16;

  // Top offset that ends a column
  localparam logic [ByteW-1:0] ColumnEnd = 8'hFF;

  typedef struct packed {
    logic [BaseW-1:0]  frame_base;
    logic [LineW-1:0]  line_width;
    logic [ScaleW-1:0] vert_scale;
    logic [StepW-1:0]  vert_step;
    logic              translate_enable;
    logic [ByteW-1:0]  translate_base;
    logic [ByteW-1:0]  translate_mask;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // latch the accepted column beat
    logic mul_scale;  // byte times vertical scale
    logic mul_width;  // start row times line width
    logic set_addr;   // first row address of the post
    logic set_total;  // post length and row count, clear run counters
    logic start_run;  // clear per-byte write count
    logic emit;       // load one pixel write into the output register
    logic finish;     // close the current byte
    logic pad;        // current byte is the trailing pad byte
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic byte_end;    // incoming byte is the column end marker
    logic len_zero;    // stored post length is zero
    logic row_ok;      // another row can be written now
    logic row_ok_next; // another row can follow the one written now
    logic out_free;    // output register can take a write this cycle
    logic idx_done;    // this data byte is the last of the post
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/pcpr_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module pcpr_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [pcpr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pcpr_pkg::CfgDataW-1:0] cfg_data_i,
  output pcpr_pkg::cfg_t                cfg_o
);

  localparam logic [pcpr_pkg::CfgIdxW-1:0] RegFrameBase  = 3'd0;
  localparam logic [pcpr_pkg::CfgIdxW-1:0] RegLineWidth  = 3'd1;
  localparam logic [pcpr_pkg::CfgIdxW-1:0] RegVertScale  = 3'd2;
  localparam logic [pcpr_pkg::CfgIdxW-1:0] RegVertStep   = 3'd3;
  localparam logic [pcpr_pkg::CfgIdxW-1:0] RegTransEn    = 3'd4;
  localparam logic [pcpr_pkg::CfgIdxW-1:0] RegTransBase  = 3'd5;
  localparam logic [pcpr_pkg::CfgIdxW-1:0] RegTransMask  = 3'd6;

  pcpr_pkg::cfg_t cfg_q, cfg_d;

  // Decode the register index, keep the low bits of the data
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegFrameBase: cfg_d.frame_base       = cfg_data_i[pcpr_pkg::BaseW-1:0];
        RegLineWidth: cfg_d.line_width       = cfg_data_i[pcpr_pkg::LineW-1:0];
        RegVertScale: cfg_d.vert_scale       = cfg_data_i[pcpr_pkg::ScaleW-1:0];
        RegVertStep:  cfg_d.vert_step        = cfg_data_i[pcpr_pkg::StepW-1:0];
        RegTransEn:   cfg_d.translate_enable = cfg_data_i[0];
        RegTransBase: cfg_d.translate_base   = cfg_data_i[pcpr_pkg::ByteW-1:0];
        RegTransMask: cfg_d.translate_mask   = cfg_data_i[pcpr_pkg::ByteW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_base       <= '0;
      cfg_q.line_width       <= 12'd320;
      cfg_q.vert_scale       <= 20'h10000;
      cfg_q.vert_step        <= 23'h10000;
      cfg_q.translate_enable <= 1'b0;
      cfg_q.translate_base   <= '0;
      cfg_q.translate_mask   <= 8'hFF;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/pcpr_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module pcpr_dp #(
  parameter int unsigned ADDR_BITS      = 22,
  parameter int unsigned MAX_LINE_WIDTH = 2048
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pcpr_pkg::cfg_t              cfg_i,
  input  pcpr_pkg::dp_cmd_t           cmd_i,
  output pcpr_pkg::dp_status_t        status_o,
  input  logic [pcpr_pkg::ByteW-1:0]  column_byte_i,
  input  logic [pcpr_pkg::ColW-1:0]   dest_column_i,
  output logic                        pixel_valid_o,
  input  logic                        pixel_ready_i,
  output logic [ADDR_BITS-1:0]        pixel_address_o,
  output logic [pcpr_pkg::ByteW-1:0]  pixel_value_o,
  output logic                        last_of_run_o
);

  localparam int EffW   = $clog2(MAX_LINE_WIDTH + 1);
  localparam int CmpW   = (EffW > pcpr_pkg::LineW) ? EffW : pcpr_pkg::LineW;
  localparam int WProdW = pcpr_pkg::TotalW + EffW;
  localparam int SumW   = 32;
  localparam int AccHiW = pcpr_pkg::AccW - pcpr_pkg::FracBits;

  // Latched column beat and multiplier results
  logic [pcpr_pkg::ByteW-1:0] byte_q;
  logic [pcpr_pkg::ColW-1:0]  col_q;
  logic [pcpr_pkg::ProdW-1:0] prod_q;
  logic [WProdW-1:0]          wprod_q;

  // Post walk state
  logic [ADDR_BITS-1:0]        row_addr_q, row_addr_d;
  logic [pcpr_pkg::ByteW-1:0]  len_q, len_d;
  logic [pcpr_pkg::TotalW-1:0] total_q, total_d;
  logic [pcpr_pkg::TotalW-1:0] emitted_q, emitted_d;
  logic [pcpr_pkg::AccW-1:0]   acc_q, acc_d;
  logic [pcpr_pkg::IdxW-1:0]   idx_q, idx_d;
  logic [pcpr_pkg::CountW-1:0] cnt_q, cnt_d;

  // Output register
  logic                       out_valid_q, out_valid_d;
  logic [ADDR_BITS-1:0]       out_addr_q;
  logic [pcpr_pkg::ByteW-1:0] out_value_q;
  logic                       out_last_q;

  logic [EffW-1:0]                 eff_width;
  logic [pcpr_pkg::AccW:0]         acc_sum;
  logic [pcpr_pkg::AccW-1:0]       acc_next;
  logic [AccHiW-1:0]               idx_ext;
  logic [pcpr_pkg::ByteW-1:0]      color;
  logic [SumW-1:0]                 addr_sum;
  logic                            out_free;
  logic [pcpr_pkg::CountW-1:0]     cnt_inc;
  logic [pcpr_pkg::TotalW:0]       emitted_inc;
  logic [pcpr_pkg::IdxW-1:0]       idx_inc;

  // Clamp the line width to the largest supported row
  always_comb begin
    if (CmpW'(cfg_i.line_width) > CmpW'(MAX_LINE_WIDTH)) begin
      eff_width = EffW'(MAX_LINE_WIDTH);
    end else begin
      eff_width = EffW'(cfg_i.line_width);
    end
  end

  // Source position after one more row, saturating
  assign acc_sum  = {1'b0, acc_q} + (pcpr_pkg::AccW + 1)'(cfg_i.vert_step);
  assign acc_next = acc_sum[pcpr_pkg::AccW] ? '1 : acc_sum[pcpr_pkg::AccW-1:0];
  assign idx_ext  = AccHiW'(idx_q);

  assign cnt_inc     = cnt_q + 5'd1;
  assign emitted_inc = {1'b0, emitted_q} + 13'd1;
  assign idx_inc     = idx_q + 9'd1;

  // Pixel value, raw or translated
  assign color = cfg_i.translate_enable ?
                 (cfg_i.translate_base + (byte_q & cfg_i.translate_mask)) : byte_q;

  assign addr_sum = SumW'(cfg_i.frame_base) + SumW'(col_q) + SumW'(wprod_q);

  assign out_free = !out_valid_q || pixel_ready_i;

  // Status for the controller
  always_comb begin
    status_o.byte_end    = (column_byte_i == pcpr_pkg::ColumnEnd);
    status_o.len_zero    = (len_q == '0);
    status_o.out_free    = out_free;
    status_o.idx_done    = (idx_inc >= pcpr_pkg::IdxW'(len_q));
    status_o.row_ok      = (cnt_q < pcpr_pkg::CountW'(pcpr_pkg::ResCap)) &&
                           (emitted_q < total_q) &&
                           (cmd_i.pad ||
                            (acc_q[pcpr_pkg::AccW-1:pcpr_pkg::FracBits] <= idx_ext));
    status_o.row_ok_next = (cnt_inc < pcpr_pkg::CountW'(pcpr_pkg::ResCap)) &&
                           (emitted_inc < {1'b0, total_q}) &&
                           (cmd_i.pad ||
                            (acc_next[pcpr_pkg::AccW-1:pcpr_pkg::FracBits] <= idx_ext));
  end

  // Next values of the post walk state
  always_comb begin
    row_addr_d  = row_addr_q;
    len_d       = len_q;
    total_d     = total_q;
    emitted_d   = emitted_q;
    acc_d       = acc_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (pixel_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.set_addr) begin
      row_addr_d = addr_sum[ADDR_BITS-1:0];
    end
    if (cmd_i.set_total) begin
      len_d     = byte_q;
      total_d   = prod_q[pcpr_pkg::ProdW-1:pcpr_pkg::FracBits];
      emitted_d = '0;
      acc_d     = '0;
      idx_d     = '0;
    end
    if (cmd_i.start_run) begin
      cnt_d = '0;
    end
    if (cmd_i.emit) begin
      row_addr_d  = row_addr_q + ADDR_BITS'(eff_width);
      emitted_d   = emitted_inc[pcpr_pkg::TotalW-1:0];
      acc_d       = acc_next;
      cnt_d       = cnt_inc;
      out_valid_d = 1'b1;
    end
    if (cmd_i.finish) begin
      if (cmd_i.pad) begin
        emitted_d = total_q;
      end else begin
        idx_d = idx_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_addr_q  <= '0;
      len_q       <= '0;
      total_q     <= '0;
      emitted_q   <= '0;
      acc_q       <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      row_addr_q  <= row_addr_d;
      len_q       <= len_d;
      total_q     <= total_d;
      emitted_q   <= emitted_d;
      acc_q       <= acc_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q <= column_byte_i;
      col_q  <= dest_column_i;
    end
    if (cmd_i.mul_scale) begin
      prod_q <= byte_q * cfg_i.vert_scale;
    end
    if (cmd_i.mul_width) begin
      wprod_q <= prod_q[pcpr_pkg::ProdW-1:pcpr_pkg::FracBits] * eff_width;
    end
    if (cmd_i.emit) begin
      out_addr_q  <= row_addr_q;
      out_value_q <= color;
      out_last_q  <= !status_o.row_ok_next;
    end
  end

  assign pixel_valid_o   = out_valid_q;
  assign pixel_address_o = out_addr_q;
  assign pixel_value_o   = out_value_q;
  assign last_of_run_o   = out_last_q;

endmodule

`default_nettype wire

FILE: rtl/pcpr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pcpr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 column_valid_i,
  input  logic                 column_start_i,
  output logic                 column_ready_o,
  input  pcpr_pkg::dp_status_t status_i,
  output pcpr_pkg::dp_cmd_t    cmd_o
);

  // Sequencer states
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StMulS  = 3'd1;
  localparam logic [2:0] StMulW  = 3'd2;
  localparam logic [2:0] StAddr  = 3'd3;
  localparam logic [2:0] StTotal = 3'd4;
  localparam logic [2:0] StEmit  = 3'd5;

  // Column parse phases
  localparam logic [2:0] PhTop  = 3'd0;
  localparam logic [2:0] PhLen  = 3'd1;
  localparam logic [2:0] PhPad1 = 3'd2;
  localparam logic [2:0] PhData = 3'd3;
  localparam logic [2:0] PhPad2 = 3'd4;
  localparam logic [2:0] PhDone = 3'd5;

  logic [2:0] state_q, state_d;
  logic [2:0] phase_q, phase_d;
  logic [2:0] phase_in;
  logic       accept;

  assign column_ready_o = (state_q == StIdle);
  assign accept         = column_ready_o && column_valid_i;
  assign phase_in       = column_start_i ? PhTop : phase_q;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          unique case (phase_in)
            PhTop: begin
              if (status_i.byte_end) begin
                phase_d = PhDone;
              end else begin
                phase_d = PhLen;
                state_d = StMulS;
              end
            end
            PhLen: begin
              phase_d = PhPad1;
              state_d = StMulS;
            end
            PhPad1: begin
              phase_d = status_i.len_zero ? PhPad2 : PhData;
            end
            PhData, PhPad2: begin
              cmd_o.start_run = 1'b1;
              state_d         = StEmit;
            end
            default: begin
              phase_d = phase_in;
            end
          endcase
        end
      end
      // Phase already points past the byte: length next means a top offset
      StMulS: begin
        cmd_o.mul_scale = 1'b1;
        state_d         = (phase_q == PhLen) ? StMulW : StTotal;
      end
      StMulW: begin
        cmd_o.mul_width = 1'b1;
        state_d         = StAddr;
      end
      StAddr: begin
        cmd_o.set_addr = 1'b1;
        state_d        = StIdle;
      end
      StTotal: begin
        cmd_o.set_total = 1'b1;
        state_d         = StIdle;
      end
      // Write rows one per cycle while the output register is free, close the byte with the last one
      StEmit: begin
        cmd_o.pad = (phase_q == PhPad2);
        if (!status_i.row_ok) begin
          cmd_o.finish = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.finish = !status_i.row_ok_next;
        end
        if (cmd_o.finish) begin
          state_d = StIdle;
          if (cmd_o.pad) begin
            phase_d = PhTop;
          end else begin
            phase_d = status_i.idx_done ? PhPad2 : PhData;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      phase_q <= PhTop;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/patch_column_post_renderer_unit.sv
// Column post renderer: turns the byte stream of one picture column into
// framebuffer pixel writes, scaled vertically by a 4.16 fixed point factor.
// Channels: column beats (column_byte, column_start, dest_column) in,
// pixel beats (pixel_address, pixel_value, last_of_run) out, and a write
// port for the seven configuration registers, always ready.
// Work per column beat, from acceptance until the next beat can be
// taken: a top offset runs byte times scale, start row times line
// width, then the address add; a length runs one multiply; the first
// pad byte and the column end need no further step; data and trailing
// pad bytes then issue their pixel writes, held by any output stall.
// The first pixel of a byte enters the output register from the emit
// state after acceptance. Reset clears the parser to wait for a top
// offset and loads register defaults. A stalled receiver holds the
// output register and the row walk; the next column beat is taken once
// the last write of the current one sits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module patch_column_post_renderer_unit #(
  parameter int unsigned ADDR_BITS      = 22,
  parameter int unsigned MAX_LINE_WIDTH = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pcpr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pcpr_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          column_valid_i,
  output logic                          column_ready_o,
  input  logic [pcpr_pkg::ByteW-1:0]    column_byte_i,
  input  logic                          column_start_i,
  input  logic [pcpr_pkg::ColW-1:0]     dest_column_i,
  output logic                          pixel_valid_o,
  input  logic                          pixel_ready_i,
  output logic [ADDR_BITS-1:0]          pixel_address_o,
  output logic [pcpr_pkg::ByteW-1:0]    pixel_value_o,
  output logic                          last_of_run_o
);

  pcpr_pkg::cfg_t       cfg;
  pcpr_pkg::dp_cmd_t    cmd;
  pcpr_pkg::dp_status_t status;

  // Register writes complete in one beat
  assign cfg_ready_o = 1'b1;

  pcpr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pcpr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .column_valid_i (column_valid_i),
    .column_start_i (column_start_i),
    .column_ready_o (column_ready_o),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  pcpr_dp #(
    .ADDR_BITS      (ADDR_BITS),
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .status_o        (status),
    .column_byte_i   (column_byte_i),
    .dest_column_i   (dest_column_i),
    .pixel_valid_o   (pixel_valid_o),
    .pixel_ready_i   (pixel_ready_i),
    .pixel_address_o (pixel_address_o),
    .pixel_value_o   (pixel_value_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

`default_nettype wire

FILE: rtl/pcpr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "patch_column_post_renderer_unit_defines.svh"

module pcpr_checker #(
  parameter int unsigned ADDR_BITS = 22
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 column_ready_o,
  input logic                 pixel_valid_o,
  input logic                 pixel_ready_i,
  input logic [ADDR_BITS-1:0] pixel_address_o,
  input logic                 last_of_run_o
);

  // Hold a pixel beat until it is taken
  `PCPR_ASSERT(a_pixel_hold, pixel_valid_o && !pixel_ready_i |=> pixel_valid_o, "pixel beat dropped")
  `PCPR_ASSERT_STABLE(a_pixel_addr_stable, pixel_valid_o, pixel_ready_i, pixel_address_o, "pixel address moved")
  // A run that is not finished keeps the column channel closed
  `PCPR_ASSERT(a_run_blocks_input, pixel_valid_o && !last_of_run_o |-> !column_ready_o, "column taken mid run")
  // A new write only ever follows a cycle of column processing
  `PCPR_ASSERT(a_write_after_busy, $rose(pixel_valid_o) |-> !$past(column_ready_o), "write without work")

endmodule

bind patch_column_post_renderer_unit pcpr_checker #(.ADDR_BITS(ADDR_BITS)) u_pcpr_checker (.*);

`default_nettype wire
